// File: rtl/clwd_pkg.sv
// Shared types and constants for the character display write formatter.
// Holds the microcode word layout, step addresses and datapath control structs.
// No dependencies.
`timescale 1ns / 1ps

package clwd_pkg;

  localparam int OpW      = 2;
  localparam int OperandW = 32;
  localparam int ByteW    = 8;
  localparam int NibW     = 4;
  localparam int DigitW   = 4;

  localparam logic [OpW-1:0] OP_CMD  = 2'd0;
  localparam logic [OpW-1:0] OP_DATA = 2'd1;
  localparam logic [OpW-1:0] OP_NUM  = 2'd2;

  localparam logic [ByteW-1:0] DIGIT_BASE = 8'h30;

  // floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for every 32-bit v
  localparam logic [OperandW-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int                  RECIP_SHIFT = 35;
  localparam int                  QuotW       = 2 * OperandW - RECIP_SHIFT;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_IDLE    = 3'd0;
  localparam upc_t UPC_MUL     = 3'd1;
  localparam upc_t UPC_SPLIT   = 3'd2;
  localparam upc_t UPC_EMIT_HI = 3'd3;
  localparam upc_t UPC_EMIT_LO = 3'd4;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_HI,
    EM_LO
  } emit_e;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_MUL,
    DP_SPLIT
  } dp_op_e;

  typedef enum logic [2:0] {
    BR_JUMP,
    BR_DISPATCH,
    BR_SPLIT,
    BR_HI,
    BR_DONE
  } br_e;

  typedef struct packed {
    emit_e  emit;
    dp_op_e dp;
    br_e    br;
    upc_t   target;
  } ucode_t;

  typedef struct packed {
    dp_op_e op;
    logic   load;
    logic   pop;
  } dp_ctrl_t;

  typedef struct packed {
    logic              more;
    logic              pending;
    logic [DigitW-1:0] digit;
    logic [DigitW-1:0] next_digit;
  } dp_stat_t;

endpackage

// File: rtl/clwd_ucode_rom.sv
// Microcode table for the formatter sequencer: one control word per step.
// Depends on clwd_pkg.
`timescale 1ns / 1ps

module clwd_ucode_rom (
  input  clwd_pkg::upc_t   upc_i,
  output clwd_pkg::ucode_t word_o
);
  import clwd_pkg::*;

  always_comb begin
    case (upc_i)
      UPC_IDLE:    word_o = '{emit: EM_NONE, dp: DP_NONE,  br: BR_DISPATCH, target: UPC_MUL};
      UPC_MUL:     word_o = '{emit: EM_NONE, dp: DP_MUL,   br: BR_JUMP,     target: UPC_SPLIT};
      UPC_SPLIT:   word_o = '{emit: EM_NONE, dp: DP_SPLIT, br: BR_SPLIT,    target: UPC_MUL};
      UPC_EMIT_HI: word_o = '{emit: EM_HI,   dp: DP_NONE,  br: BR_HI,       target: UPC_EMIT_HI};
      UPC_EMIT_LO: word_o = '{emit: EM_LO,   dp: DP_NONE,  br: BR_DONE,     target: UPC_EMIT_HI};
      default:     word_o = '{emit: EM_NONE, dp: DP_NONE,  br: BR_JUMP,     target: UPC_IDLE};
    endcase
  end

endmodule

// File: rtl/clwd_datapath.sv
// Decimal datapath: divide-by-ten unit (registered multiply, then split) and digit buffer.
// Depends on clwd_pkg.
`timescale 1ns / 1ps

module clwd_datapath #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  clwd_pkg::dp_ctrl_t                  ctrl_i,
  input  logic [clwd_pkg::OperandW-1:0]       operand_i,
  output clwd_pkg::dp_stat_t                  stat_o
);
  import clwd_pkg::*;

  localparam int CntW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [OperandW-1:0]   val_q, val_d;
  logic [2*OperandW-1:0] prod_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DigitW-1:0]     buf_q [MAX_DIGITS];

  logic [QuotW-1:0]      quot;
  logic [OperandW-1:0]   quot_ext;
  logic [OperandW-1:0]   tenfold;
  logic [OperandW-1:0]   rem;
  logic                  more;

  assign quot     = prod_q[2*OperandW-1:RECIP_SHIFT];
  assign quot_ext = OperandW'(quot);
  assign tenfold  = (quot_ext << 3) + (quot_ext << 1);
  assign rem      = val_q - tenfold;
  assign more     = (quot != '0) && (cnt_q != CntW'(MAX_DIGITS - 1));

  assign stat_o.more       = more;
  assign stat_o.pending    = (cnt_q != '0);
  assign stat_o.digit      = rem[DigitW-1:0];
  assign stat_o.next_digit = buf_q[cnt_q - CntW'(1)];

  always_comb begin
    val_d = val_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      val_d = operand_i;
      cnt_d = '0;
    end else if (ctrl_i.op == DP_SPLIT) begin
      val_d = quot_ext;
      if (more) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (ctrl_i.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (ctrl_i.op == DP_MUL) begin
      prod_q <= (2*OperandW)'(val_q) * (2*OperandW)'(RECIP10);
    end
    if (ctrl_i.op == DP_SPLIT && more) begin
      buf_q[cnt_q] <= rem[DigitW-1:0];
    end
  end

endmodule

// File: rtl/char_lcd_write_with_decimal_format.sv
// Character display write formatter: microcoded sequencer, output register, mode register.
// Depends on clwd_pkg, clwd_ucode_rom and clwd_datapath.
//
//   channel   direction  fields
//   s_axis    in         tuser = opcode[1:0], tdata = operand[31:0]
//   m_axis    out        tuser = reg_select, tdata = bus_value[7:0], tlast = last
//   cfg       in         cfg_wdata_i = nibble_mode
//
// A request is taken in the idle step; command and data bytes then emit one transfer
// (two in 4-bit mode), one per cycle. A number runs each digit through the shared
// divide-by-ten unit (multiply step, then split step), then emits its transfers one
// per cycle. Output stalls hold the emit step; the last transfer waits in the output
// register while the next request is accepted.
// Reset sets 4-bit mode; no clearing pass.
`timescale 1ns / 1ps

module char_lcd_write_with_decimal_format #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [clwd_pkg::OperandW-1:0]   s_axis_tdata,   // operand[31:0]
  input  logic [clwd_pkg::OpW-1:0]        s_axis_tuser,   // opcode[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [clwd_pkg::ByteW-1:0]      m_axis_tdata,   // bus_value[7:0]
  output logic                            m_axis_tuser,   // reg_select
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i
);
  import clwd_pkg::*;

  upc_t             upc_q, upc_d;
  ucode_t           word;
  dp_ctrl_t         dp_ctrl;
  dp_stat_t         dp_stat;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             rs_q, rs_d;
  logic             nib_q;
  logic             accept, out_free, fire, byte_end, last_d;
  logic [ByteW-1:0] bus_d;

  clwd_ucode_rom u_rom (
    .upc_i  (upc_q),
    .word_o (word)
  );

  clwd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (dp_ctrl),
    .operand_i (s_axis_tdata),
    .stat_o    (dp_stat)
  );

  assign s_axis_tready = (upc_q == UPC_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = (word.emit != EM_NONE) && out_free;
  assign byte_end      = fire && (word.emit == EM_LO || !nib_q);
  assign last_d        = (word.emit == EM_LO || !nib_q) && !dp_stat.pending;

  always_comb begin
    if (word.emit == EM_LO) begin
      bus_d = {{(ByteW-NibW){1'b0}}, byte_q[NibW-1:0]};
    end else if (nib_q) begin
      bus_d = {{(ByteW-NibW){1'b0}}, byte_q[ByteW-1:NibW]};
    end else begin
      bus_d = byte_q;
    end
  end

  always_comb begin
    upc_d        = upc_q;
    byte_d       = byte_q;
    rs_d         = rs_q;
    dp_ctrl.op   = word.dp;
    dp_ctrl.load = accept;
    dp_ctrl.pop  = 1'b0;
    case (word.br)
      BR_JUMP: begin
        upc_d = word.target;
      end
      BR_DISPATCH: begin
        if (accept) begin
          rs_d   = (s_axis_tuser != OP_CMD);
          byte_d = s_axis_tdata[ByteW-1:0];
          case (s_axis_tuser)
            OP_CMD, OP_DATA: begin
              upc_d = UPC_EMIT_HI;
            end
            OP_NUM: begin
              if (s_axis_tdata == '0) begin
                byte_d = DIGIT_BASE;
                upc_d  = UPC_EMIT_HI;
              end else if (!s_axis_tdata[OperandW-1]) begin
                upc_d = word.target;
              end
            end
            default: ;
          endcase
        end
      end
      BR_SPLIT: begin
        if (dp_stat.more) begin
          upc_d = word.target;
        end else begin
          upc_d  = UPC_EMIT_HI;
          byte_d = DIGIT_BASE | {{(ByteW-DigitW){1'b0}}, dp_stat.digit};
        end
      end
      BR_HI: begin
        if (fire && nib_q) begin
          upc_d = UPC_EMIT_LO;
        end
      end
      BR_DONE: ;
      default: upc_d = UPC_IDLE;
    endcase
    if (byte_end) begin
      if (dp_stat.pending) begin
        dp_ctrl.pop = 1'b1;
        byte_d      = DIGIT_BASE | {{(ByteW-DigitW){1'b0}}, dp_stat.next_digit};
        upc_d       = word.target;
      end else begin
        upc_d = UPC_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q         <= UPC_IDLE;
      nib_q         <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_we_i) begin
        nib_q <= cfg_wdata_i;
      end
      if (fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rs_q   <= rs_d;
    if (fire) begin
      m_axis_tdata <= bus_d;
      m_axis_tuser <= rs_q;
      m_axis_tlast <= last_d;
    end
  end

endmodule

// File: rtl/clwd_checker.sv
// Port-level checks for the formatter, bound to the top level.
// Depends on clwd_pkg and char_lcd_write_with_decimal_format (bind target).
`timescale 1ns / 1ps

module clwd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        cfg_we_i,
  input logic        cfg_wdata_i
);
  import clwd_pkg::*;

  logic nib_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_q <= 1'b1;
    end else if (cfg_we_i) begin
      nib_q <= cfg_wdata_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  a_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && nib_q |-> m_axis_tdata[7:4] == 4'h0)
    else $error("upper nibble set in 4-bit mode");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("new request taken before the last transfer");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser != OP_CMD && s_axis_tuser != OP_DATA &&
       (s_axis_tuser != OP_NUM || s_axis_tdata[OperandW-1]))
      |=> s_axis_tready)
    else $error("silent request did not return to idle");

endmodule

bind char_lcd_write_with_decimal_format clwd_checker u_clwd_checker (.*);

// File: sim/char_lcd_write_with_decimal_format_test.sv
// Self-checking testbench for char_lcd_write_with_decimal_format: directed corner cases and
// random command, data and number requests in both bus widths, with random idling on both ports.
// Depends on clwd_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 1ps

module char_lcd_write_with_decimal_format_test;
  import clwd_pkg::*;

  localparam int MaxDigits    = 10;
  localparam int SettleCycles = 4 * MaxDigits + 8;
  localparam int StallLimit   = 1000;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic             rs;
    logic [ByteW-1:0] bus;
    logic             last;
  } lcd_xfer_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OperandW-1:0] s_axis_tdata  = '0;  // operand[31:0]
  logic [OpW-1:0]      s_axis_tuser  = '0;  // opcode[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ByteW-1:0]    m_axis_tdata;        // bus_value[7:0]
  logic                m_axis_tuser;        // reg_select
  logic                m_axis_tlast;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_wdata_i   = 1'b0;

  lcd_xfer_t lcd_expected[$];
  logic      lcd_nibble_mode = 1'b1;
  logic      steady_flow     = 1'b0;
  int        mismatch_count  = 0;
  int        stall_cycles    = 0;

  char_lcd_write_with_decimal_format #(
    .MAX_DIGITS(MaxDigits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= 12);
  end

  // Bytes of one request, then split into bus transfers for the current width.
  function automatic void predict_transfers(input logic [OpW-1:0] op,
                                            input logic [OperandW-1:0] val);
    logic [ByteW-1:0]    text[$];
    logic [OperandW-1:0] rest;
    logic                rs;
    logic                is_end;
    rs = (op != OP_CMD);
    case (op)
      OP_CMD, OP_DATA: text.push_back(val[ByteW-1:0]);
      OP_NUM: begin
        if (val == '0) begin
          text.push_back(DIGIT_BASE);
        end else if (!val[OperandW-1]) begin
          rest = val;
          while (rest != '0 && text.size() < MaxDigits) begin
            text.push_front(DIGIT_BASE + 8'(rest % 32'd10));
            rest = rest / 32'd10;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < text.size(); i++) begin
      is_end = (i == text.size() - 1);
      if (lcd_nibble_mode) begin
        lcd_expected.push_back('{rs, {4'h0, text[i][7:4]}, 1'b0});
        lcd_expected.push_back('{rs, {4'h0, text[i][3:0]}, is_end});
      end else begin
        lcd_expected.push_back('{rs, text[i], is_end});
      end
    end
  endfunction

  always @(posedge clk_i) begin : check_transfers
    lcd_xfer_t want;
    lcd_xfer_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata, m_axis_tlast};
      if (lcd_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transfer: rs=%0b bus=%02h last=%0b", got.rs, got.bus, got.last);
      end else begin
        want = lcd_expected.pop_front();
        if (got.rs !== want.rs || got.bus !== want.bus || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"transfer mismatch: expected rs=%0b bus=%02h last=%0b, ",
                      "got rs=%0b bus=%02h last=%0b"},
                     want.rs, want.bus, want.last, got.rs, got.bus, got.last);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_transfers(s_axis_tuser, s_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("char_lcd_write_with_decimal_format_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Entered and left at a falling edge; tvalid stays high for back-to-back requests.
  task automatic send_request(input logic [OpW-1:0] op, input logic [OperandW-1:0] val);
    while (!steady_flow && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (lcd_expected.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_nibble_mode(input logic nibble);
    wait_until_idle();
    cfg_we_i        <= 1'b1;
    cfg_wdata_i     <= nibble;
    lcd_nibble_mode = nibble;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_corner_cases();
    send_request(OP_CMD, 32'h0000_0000);
    send_request(OP_CMD, 32'hFFFF_FFFF);
    send_request(OP_DATA, 32'h0000_0041);
    send_request(OP_DATA, 32'h5A5A_00A5);
    send_request(OP_NUM, 32'd0);
    send_request(OP_NUM, 32'd9);
    send_request(OP_NUM, 32'd10);
    send_request(OP_NUM, 32'd1_000_000_000);
    send_request(OP_NUM, 32'h7FFF_FFFF);
    send_request(OP_NUM, 32'hFFFF_FFFF);    // -1: prints nothing
    send_request(OP_NUM, 32'h8000_0000);    // most negative
    send_request(OP_UNUSED, 32'h1234_5678);  // ignored
  endtask

  task automatic test_reset_width();
    send_corner_cases();
  endtask

  task automatic test_byte_width();
    set_nibble_mode(1'b0);
    send_corner_cases();
  endtask

  task automatic test_random_traffic();
    logic [OpW-1:0]      op;
    logic [OperandW-1:0] val;
    int                  pick;
    for (int phase = 0; phase < 6; phase++) begin
      set_nibble_mode(phase % 2 == 1);
      steady_flow <= (phase == 3);
      for (int n = 0; n < 55; n++) begin
        pick = $urandom_range(99);
        val  = $urandom;
        if (pick < 25) begin
          op = OP_CMD;
        end else if (pick < 45) begin
          op = OP_DATA;
        end else if (pick < 95) begin
          op   = OP_NUM;
          pick = $urandom_range(99);
          if (pick < 8)
            val = '0;
          else if (pick < 20)
            val[OperandW-1] = 1'b1;
          else
            val = {1'b0, val[OperandW-2:0]} >> $urandom_range(30);
        end else begin
          op = OP_UNUSED;
        end
        send_request(op, val);
      end
    end
    steady_flow <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_width();
    test_byte_width();
    test_random_traffic();
    wait_until_idle();
    if (mismatch_count == 0 && lcd_expected.size() == 0) begin
      $display("char_lcd_write_with_decimal_format_test: PASS");
    end else begin
      $display("char_lcd_write_with_decimal_format_test: FAIL");
    end
    $finish;
  end

endmodule
